/* rtl/lpp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and rotation helpers for the landmark projection unit.
// Used by lpp_div, landmark_pinhole_projection_unit and lpp_checker; no dependencies.
package lpp_pkg;

  // Matrix entry, Q.20 after rounding
  localparam int MW = 28;
  // Landmark minus position, Q16.16
  localparam int DW = 33;
  // Body-frame point after saturation, Q16.16
  localparam int BW = 36;
  // Camera-frame point, Q16.16
  localparam int CW = 44;
  // Focal times lateral coordinate
  localparam int NW = 61;
  // Divisor width (positive camera depth)
  localparam int DENW = 43;
  // Quotient bits: offset range of the pixel quotient
  localparam int QB = 17;
  localparam int DIV_STAGES = QB + 1;
  // Largest image side in whole pixels
  localparam logic [12:0] MAX_DIM = 13'd4096;

  typedef enum logic [1:0] {
    ST_VISIBLE = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_IMG_W     = 3'd4,
    REG_IMG_H     = 3'd5,
    REG_MOUNT_ROT = 3'd6,
    REG_MOUNT_OFS = 3'd7
  } reg_idx_t;

  typedef logic signed [MW-1:0] ent_t;
  typedef ent_t mat_t [9];

  typedef struct packed {
    logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  } qprod_t;

  // Divider result word
  typedef struct packed {
    logic          oor;
    logic [QB-1:0] q;
  } div_res_t;

  function automatic qprod_t quat_prod(input logic signed [15:0] w, x, y, z);
    qprod_t p;
    p.xx = x * x;
    p.yy = y * y;
    p.zz = z * z;
    p.xy = x * y;
    p.xz = x * z;
    p.yz = y * z;
    p.wx = w * x;
    p.wy = w * y;
    p.wz = w * z;
    return p;
  endfunction

  function automatic logic signed [35:0] x36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  // Round half up from Q.28 to Q.20
  function automatic ent_t rnd8(input logic signed [35:0] e);
    logic signed [35:0] t;
    t = e + 36'sd128;
    return t[35:8];
  endfunction

  // Rotation matrix, row-major, from quaternion products
  function automatic mat_t quat_mat(input qprod_t p);
    logic signed [35:0] e [9];
    mat_t m;
    e[0] = 36'sd268435456 - ((x36(p.yy) + x36(p.zz)) <<< 1);
    e[1] = (x36(p.xy) - x36(p.wz)) <<< 1;
    e[2] = (x36(p.xz) + x36(p.wy)) <<< 1;
    e[3] = (x36(p.xy) + x36(p.wz)) <<< 1;
    e[4] = 36'sd268435456 - ((x36(p.xx) + x36(p.zz)) <<< 1);
    e[5] = (x36(p.yz) - x36(p.wx)) <<< 1;
    e[6] = (x36(p.xz) - x36(p.wy)) <<< 1;
    e[7] = (x36(p.yz) + x36(p.wx)) <<< 1;
    e[8] = 36'sd268435456 - ((x36(p.xx) + x36(p.yy)) <<< 1);
    for (int i = 0; i < 9; i++) begin
      m[i] = rnd8(e[i]);
    end
    return m;
  endfunction

endpackage

/* rtl/lpp_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider for the pixel quotient: an offset stage, then one quotient bit per stage.
// Depends on lpp_pkg; stage enables come from the top level's stall chain.
module lpp_div (
  input  logic                         clk,
  input  logic [lpp_pkg::QB:0]         en,
  input  logic signed [lpp_pkg::NW-1:0] num,
  input  logic [lpp_pkg::DENW-1:0]     den,
  output lpp_pkg::div_res_t            res
);
  import lpp_pkg::*;

  logic [NW-1:0]   rem_r [0:QB-1];
  logic [DENW-1:0] den_r [0:QB-1];
  logic [QB-1:0]   q_r   [0:QB];
  logic            oor_r [0:QB];

  logic signed [NW:0] np;
  logic               oor_nxt;
  logic [NW:0]        trial [1:QB];
  logic [NW-1:0]      dsh   [1:QB];

  // Offset the quotient by 2^16 so it is non-negative, flag anything out of range
  always_comb begin
    np      = (NW+1)'(num) + $signed({3'b000, den, 16'h0000});
    oor_nxt = np[NW] | ({1'b0, np[NW-1:0]} >= {2'b00, den, 17'h00000});
  end

  // Trial subtract per stage
  always_comb begin
    for (int s = 1; s <= QB; s++) begin
      dsh[s]   = {{(NW-DENW){1'b0}}, den_r[s-1]} << (QB - s);
      trial[s] = {1'b0, rem_r[s-1]} - {1'b0, dsh[s]};
    end
  end

  // Advance each stage when its enable is set
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= np[NW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      oor_r[0] <= oor_nxt;
    end
    for (int s = 1; s <= QB; s++) begin
      if (en[s]) begin
        q_r[s]   <= {q_r[s-1][QB-2:0], ~trial[s][NW]};
        oor_r[s] <= oor_r[s-1];
      end
    end
    // The last stage keeps only the quotient
    for (int s = 1; s < QB; s++) begin
      if (en[s]) begin
        rem_r[s] <= trial[s][NW] ? rem_r[s-1] : trial[s][NW-1:0];
        den_r[s] <= den_r[s-1];
      end
    end
  end

  assign res.q   = q_r[QB];
  assign res.oor = oor_r[QB];

endmodule

/* rtl/landmark_pinhole_projection_unit.sv */
`timescale 1ns / 1ps
// Top level of the landmark pinhole projection unit: pose composition, projection,
// image bounds test. Depends on lpp_pkg and lpp_div.
//
// Usage
//   in_*  : one word per landmark: body quaternion, body position, landmark point.
//   out_* : one word per landmark: status in out_tuser, u and v pixels in out_tdata.
//   cfg_* : register writes, index 0..7 in the order focal x/y, centre x/y, image
//           width/height, mount rotation, mount offset. Write only while idle.
// Timing
//   A word is taken in every cycle in which in_tready is high. Its result shows on out_tvalid
//   through 26 register stages: 7 stages of pose and projection arithmetic,
//   18 divider stages (an offset stage, then one quotient bit each) and the output register.
//   Mount rotation writes reach the rotation matrix register through mprod_r.
// Reset
//   rst_n (synchronous) empties the pipeline and loads the register defaults.
// Stalls
//   Each stage holds when the next one is full and holding, so bubbles are
//   squeezed out and in_tready stays high until every stage is full.
//   Non-visible results carry zero pixels.
module landmark_pinhole_projection_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // qw, qx, qy, qz (16b each), tx, ty, tz, landmark x, y, z (32b each)
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // u_pixel [15:0], v_pixel [31:16]
  output logic [31:0]  out_tdata,
  // status [1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  import lpp_pkg::*;

  localparam int DIV0 = 7;
  localparam int NS   = DIV0 + DIV_STAGES + 1;

  // Configuration registers
  logic [15:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [12:0] image_w_r, image_h_r;
  logic [63:0] mount_rot_r;
  logic [47:0] mount_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= 16'd8000;
      focal_y_r   <= 16'd8000;
      center_x_r  <= 16'd5120;
      center_y_r  <= 16'd3840;
      image_w_r   <= 13'd640;
      image_h_r   <= 13'd480;
      mount_rot_r <= 64'h4000_0000_0000_0000;
      mount_ofs_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FOCAL_X:   focal_x_r   <= cfg_wdata[15:0];
        REG_FOCAL_Y:   focal_y_r   <= cfg_wdata[15:0];
        REG_CENTER_X:  center_x_r  <= cfg_wdata[15:0];
        REG_CENTER_Y:  center_y_r  <= cfg_wdata[15:0];
        REG_IMG_W:     image_w_r   <= cfg_wdata[12:0];
        REG_IMG_H:     image_h_r   <= cfg_wdata[12:0];
        REG_MOUNT_ROT: mount_rot_r <= cfg_wdata;
        REG_MOUNT_OFS: mount_ofs_r <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  // Mount rotation matrix, rebuilt continuously from the register
  qprod_t mprod_r;
  mat_t   mmat_r;

  always_ff @(posedge clk) begin
    mprod_r <= quat_prod(mount_rot_r[63:48], mount_rot_r[47:32],
                         mount_rot_r[31:16], mount_rot_r[15:0]);
    mmat_r  <= quat_mat(mprod_r);
  end

  // Stall chain: a stage advances when it is empty or the next one advances
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = ~vld_r[NS-1] | out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_tready = adv[0];

  // Stage 0: pose quaternion products, landmark minus position
  qprod_t               pprod_r;
  logic signed [DW-1:0] d0_r [3];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pprod_r <= quat_prod(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32],
                           in_tdata[63:48]);
      for (int i = 0; i < 3; i++) begin
        d0_r[i] <= DW'($signed(in_tdata[160+32*i +: 32]))
                 - DW'($signed(in_tdata[64+32*i +: 32]));
      end
    end
  end

  // Stage 1: pose rotation matrix
  mat_t                 rp_r;
  logic signed [DW-1:0] d1_r [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rp_r <= quat_mat(pprod_r);
      d1_r <= d0_r;
    end
  end

  // Stage 2: transpose products of the pose rotation
  logic signed [62:0] pr_r [9];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i*3+j] <= 63'(rp_r[j*3+i]) * 63'(d1_r[j]);
        end
      end
    end
  end

  // Stage 3: sum, round to Q16.16, subtract mount offset, saturate
  logic signed [62:0] acc1 [3];
  logic signed [43:0] bdif [3];
  logic signed [BW-1:0] b_nxt [3];
  logic signed [BW-1:0] b_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc1[i] = pr_r[i*3] + pr_r[i*3+1] + pr_r[i*3+2] + 63'sd524288;
      bdif[i] = 44'($signed(acc1[i][62:20]))
              - 44'($signed({mount_ofs_r[47-16*i -: 16], 8'h00}));
      if (bdif[i][43] && (bdif[i][42:35] != 8'hFF)) begin
        b_nxt[i] = {1'b1, {(BW-1){1'b0}}};
      end else if (!bdif[i][43] && (bdif[i][42:35] != 8'h00)) begin
        b_nxt[i] = {1'b0, {(BW-1){1'b1}}};
      end else begin
        b_nxt[i] = bdif[i][BW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) b_r <= b_nxt;
  end

  // Stage 4: transpose products of the mount rotation
  logic signed [63:0] mr_r [9];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mr_r[i*3+j] <= 64'(mmat_r[j*3+i]) * 64'(b_r[j]);
        end
      end
    end
  end

  // Stage 5: camera-frame point
  logic signed [63:0]   acc2 [3];
  logic signed [CW-1:0] c_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc2[i] = mr_r[i*3] + mr_r[i*3+1] + mr_r[i*3+2] + 64'sd524288;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= acc2[i][63:20];
      end
    end
  end

  // Stage 6: focal products, behind test, divisor
  logic signed [NW-1:0] nu_r, nv_r;
  logic [DENW-1:0]      den_r;
  logic                 behind_nxt;
  logic [DIV_STAGES:0]  beh_r;

  assign behind_nxt = c_r[0][CW-1] | (c_r[0] == '0);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      nu_r     <= NW'($signed({1'b0, focal_x_r})) * NW'(c_r[1]);
      nv_r     <= NW'($signed({1'b0, focal_y_r})) * NW'(c_r[2]);
      den_r    <= behind_nxt ? DENW'(1) : c_r[0][DENW-1:0];
      beh_r[0] <= behind_nxt;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      if (adv[DIV0+s-1]) beh_r[s] <= beh_r[s-1];
    end
  end

  // Stages 7..24: divider, an offset stage then quotient bits
  div_res_t res_u, res_v;

  lpp_div u_div_u (
    .clk (clk),
    .en  (adv[DIV0 +: DIV_STAGES]),
    .num (nu_r),
    .den (den_r),
    .res (res_u)
  );

  lpp_div u_div_v (
    .clk (clk),
    .en  (adv[DIV0 +: DIV_STAGES]),
    .num (nv_r),
    .den (den_r),
    .res (res_v)
  );

  // Output stage: add principal point, bounds test
  logic [12:0]        wc, hc;
  logic [16:0]        w16, h16;
  logic signed [18:0] u19, v19;
  logic               u_bad, v_bad;
  status_t            status_nxt;
  status_t            status_r;
  logic [15:0]        u_r, v_r;

  always_comb begin
    wc    = (image_w_r > MAX_DIM) ? MAX_DIM : image_w_r;
    hc    = (image_h_r > MAX_DIM) ? MAX_DIM : image_h_r;
    w16   = {wc, 4'h0};
    h16   = {hc, 4'h0};
    u19   = $signed({2'b00, res_u.q}) + $signed({3'b000, center_x_r}) - 19'sd65536;
    v19   = $signed({2'b00, res_v.q}) + $signed({3'b000, center_y_r}) - 19'sd65536;
    u_bad = res_u.oor | u19[18] | (u19[17:0] >= {1'b0, w16});
    v_bad = res_v.oor | v19[18] | (v19[17:0] >= {1'b0, h16});
    if (beh_r[DIV_STAGES]) begin
      status_nxt = ST_BEHIND;
    end else if (u_bad || v_bad) begin
      status_nxt = ST_OUTSIDE;
    end else begin
      status_nxt = ST_VISIBLE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      status_r <= status_nxt;
      u_r      <= (status_nxt == ST_VISIBLE) ? u19[15:0] : 16'h0000;
      v_r      <= (status_nxt == ST_VISIBLE) ? v19[15:0] : 16'h0000;
    end
  end

  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {v_r, u_r};
  assign out_tuser  = status_r;

endmodule

/* rtl/lpp_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the landmark projection unit, bound to the top level.
// Depends on lpp_pkg and landmark_pinhole_projection_unit.
module lpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import lpp_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word shown right after reset");

  // A held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Points behind the camera carry no pixels
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_BEHIND) |-> (out_tdata == '0))
    else $error("behind-camera word carries pixels");

  // Points off the image carry no pixels
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OUTSIDE) |-> (out_tdata == '0))
    else $error("off-image word carries pixels");

endmodule

bind landmark_pinhole_projection_unit lpp_checker u_lpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/tb_landmark_pinhole_projection_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for landmark_pinhole_projection_unit: directed table, then random
// phases under varied camera settings, checked by an integer projection predictor.
// Depends on lpp_pkg and the unit's RTL.
module tb_landmark_pinhole_projection_unit;
  import lpp_pkg::*;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] tx, ty, tz, lx, ly, lz;
  } landmark_word_t;

  typedef struct {
    status_t     st;
    logic [15:0] u, v;
  } pixel_result_t;

  typedef struct {
    landmark_word_t w;
    bit             typed;
    pixel_result_t  res;
  } stim_row_t;

  typedef longint rot9_t [9];

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic [63:0] ROT_IDENTITY = 64'h4000_0000_0000_0000;
  localparam int WATCHDOG_LIMIT = 3000;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_wdata;

  // camera settings as the unit should hold them
  logic [15:0] focal_x, focal_y, center_x, center_y;
  logic [12:0] img_w, img_h;
  logic [63:0] mount_rot;
  logic [47:0] mount_ofs;

  pixel_result_t pending_pixels[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  stall_req = 1'b0;

  landmark_pinhole_projection_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clamp35(longint x);
    if (x < -(64'sd1 <<< 35)) return -(64'sd1 <<< 35);
    if (x > (64'sd1 <<< 35) - 1) return (64'sd1 <<< 35) - 1;
    return x;
  endfunction

  // row-major rotation, Q.20 entries
  function automatic rot9_t rot_from_quat(longint w, longint x, longint y, longint z);
    rot9_t r;
    longint one28;
    one28 = 64'sd1 <<< 28;
    r[0] = one28 - 2 * (y * y + z * z);
    r[1] = 2 * (x * y - w * z);
    r[2] = 2 * (x * z + w * y);
    r[3] = 2 * (x * y + w * z);
    r[4] = one28 - 2 * (x * x + z * z);
    r[5] = 2 * (y * z - w * x);
    r[6] = 2 * (x * z - w * y);
    r[7] = 2 * (y * z + w * x);
    r[8] = one28 - 2 * (x * x + y * y);
    for (int i = 0; i < 9; i++) r[i] = rnd_shift(r[i], 8);
    return r;
  endfunction

  function automatic pixel_result_t project_landmark(landmark_word_t p);
    rot9_t rp, rm;
    longint d[3], b[3], c[3];
    longint off, u, v, wpix, hpix;
    pixel_result_t r;
    rp = rot_from_quat(longint'(p.qw), longint'(p.qx), longint'(p.qy), longint'(p.qz));
    rm = rot_from_quat(longint'($signed(mount_rot[63:48])), longint'($signed(mount_rot[47:32])),
                       longint'($signed(mount_rot[31:16])), longint'($signed(mount_rot[15:0])));
    d[0] = longint'(p.lx) - longint'(p.tx);
    d[1] = longint'(p.ly) - longint'(p.ty);
    d[2] = longint'(p.lz) - longint'(p.tz);
    // world to body, less the mount offset, then body to camera
    for (int i = 0; i < 3; i++) begin
      b[i] = rnd_shift(rp[i] * d[0] + rp[3 + i] * d[1] + rp[6 + i] * d[2], 20);
      off = longint'($signed(mount_ofs[47 - 16 * i -: 16])) * 256;
      b[i] = clamp35(b[i] - off);
    end
    for (int i = 0; i < 3; i++)
      c[i] = rnd_shift(rm[i] * b[0] + rm[3 + i] * b[1] + rm[6 + i] * b[2], 20);
    r = '{ST_VISIBLE, 16'd0, 16'd0};
    if (c[0] <= 0) begin
      r.st = ST_BEHIND;
      return r;
    end
    wpix = (img_w > MAX_DIM) ? 4096 : longint'({51'd0, img_w});
    hpix = (img_h > MAX_DIM) ? 4096 : longint'({51'd0, img_h});
    u = floor_quot(longint'({48'd0, focal_x}) * c[1], c[0]) + longint'({48'd0, center_x});
    v = floor_quot(longint'({48'd0, focal_y}) * c[2], c[0]) + longint'({48'd0, center_y});
    if (u < 0 || u >= wpix * 16 || v < 0 || v >= hpix * 16) begin
      r.st = ST_OUTSIDE;
      return r;
    end
    r.u = u[15:0];
    r.v = v[15:0];
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [255:0] pack_word(landmark_word_t w);
    return {w.lz, w.ly, w.lx, w.tz, w.ty, w.tx, w.qz, w.qy, w.qx, w.qw};
  endfunction

  function automatic logic signed [31:0] rand_span(int half);
    return $signed($urandom_range(2 * half - 1, 0)) - half;
  endfunction

  function automatic logic [63:0] near_axis_quat();
    logic signed [15:0] q[4];
    int k;
    k = $urandom_range(3);
    for (int i = 0; i < 4; i++) q[i] = 16'(rand_span(300));
    case (k)
      0: q[0] = q[0] + 16'sd16384;
      1: begin q[0] = q[0] + 16'sd11585; q[3] = q[3] + 16'sd11585; end
      2: begin q[0] = q[0] + 16'sd11585; q[2] = q[2] - 16'sd11585; end
      default: begin q[0] = q[0] - 16'sd15137; q[1] = q[1] + 16'sd6270; end
    endcase
    return {q[0], q[1], q[2], q[3]};
  endfunction

  function automatic landmark_word_t random_word();
    landmark_word_t w;
    logic [63:0] q;
    if ($urandom_range(99) < 30) begin
      // raw noise over every bit
      {w.qw, w.qx} = $urandom;
      {w.qy, w.qz} = $urandom;
      w.tx = $urandom; w.ty = $urandom; w.tz = $urandom;
      w.lx = $urandom; w.ly = $urandom; w.lz = $urandom;
      return w;
    end
    q = near_axis_quat();
    {w.qw, w.qx, w.qy, w.qz} = q;
    w.tx = rand_span(1 << 23);
    w.ty = rand_span(1 << 23);
    w.tz = rand_span(1 << 23);
    w.lx = w.tx + rand_span(1 << 21) + (1 << 20);
    w.ly = w.ty + rand_span(1 << 20);
    w.lz = w.tz + rand_span(1 << 20);
    return w;
  endfunction

  task automatic send_word(landmark_word_t w, bit typed, pixel_result_t typed_res);
    pixel_result_t want_res;
    if (!quiet && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_word(w);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want_res = typed ? typed_res : project_landmark(w);
    pending_pixels = {pending_pixels, want_res};
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FOCAL_X:   focal_x   = val[15:0];
      REG_FOCAL_Y:   focal_y   = val[15:0];
      REG_CENTER_X:  center_x  = val[15:0];
      REG_CENTER_Y:  center_y  = val[15:0];
      REG_IMG_W:     img_w     = val[12:0];
      REG_IMG_H:     img_h     = val[12:0];
      REG_MOUNT_ROT: mount_rot = val;
      REG_MOUNT_OFS: mount_ofs = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [15:0] fx, fy, cx, cy, logic [12:0] w, h,
                            logic [63:0] rot, logic [47:0] ofs);
    write_reg(REG_FOCAL_X, 64'(fx));
    write_reg(REG_FOCAL_Y, 64'(fy));
    write_reg(REG_CENTER_X, 64'(cx));
    write_reg(REG_CENTER_Y, 64'(cy));
    write_reg(REG_IMG_W, 64'(w));
    write_reg(REG_IMG_H, 64'(h));
    write_reg(REG_MOUNT_ROT, rot);
    write_reg(REG_MOUNT_OFS, 64'(ofs));
    cfg_we <= 1'b0;
    // let the mount matrix settle
    repeat (4) @(posedge clk);
  endtask

  // ---------------- directed table ----------------
  stim_row_t directed[] = '{
    '{'{16'sd16384, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1'b1, '{ST_VISIBLE, 16'd5120, 16'd3840}},
    '{'{16'sd16384, 0, 0, 0, 0, 0, 0, -ONE, 0, 0}, 1'b1, '{ST_BEHIND, 16'd0, 16'd0}},
    '{'{16'sd16384, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{ST_BEHIND, 16'd0, 16'd0}},
    '{'{16'sd16384, 0, 0, 0, 0, 0, 0, ONE, ONE, 0}, 1'b1, '{ST_OUTSIDE, 16'd0, 16'd0}},
    '{'{16'sd16384, 0, 0, 0, 0, 0, 0, ONE, 0, -ONE}, 1'b1, '{ST_OUTSIDE, 16'd0, 16'd0}},
    '{'{-16'sd16384, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1'b1, '{ST_VISIBLE, 16'd5120, 16'd3840}},
    '{'{16'sd0, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1'b1, '{ST_VISIBLE, 16'd5120, 16'd3840}},
    '{'{16'sd16384, 0, 0, 0, ONE, ONE, ONE, 3 * ONE, ONE + 5000, ONE - 7000}, 1'b0,
      '{ST_VISIBLE, 16'd0, 16'd0}},
    '{'{16'sd11585, 0, 0, 16'sd11585, 0, 0, 0, 0, ONE, 0}, 1'b0, '{ST_VISIBLE, 16'd0, 16'd0}},
    '{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0, 0, 0, ONE, 2000, -3000}, 1'b0,
      '{ST_VISIBLE, 16'd0, 16'd0}},
    '{'{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0, 0, 0, ONE, 0, 0}, 1'b0,
      '{ST_VISIBLE, 16'd0, 16'd0}},
    '{'{16'sd16384, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, '{ST_VISIBLE, 16'd0, 16'd0}},
    '{'{16'sd16384, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '{ST_VISIBLE, 16'd0, 16'd0}},
    '{'{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 32'sh7FFF_FFFF, 0,
        32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b0, '{ST_VISIBLE, 16'd0, 16'd0}}
  };

  // ---------------- result side ----------------
  // hold off on request, otherwise stall at random unless quiet
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_tuser);
          fail_count++;
        end
        if (out_tdata[15:0] !== want.u) begin
          $error("u_pixel: expected %0d, got %0d", want.u, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[31:16] !== want.v) begin
          $error("v_pixel: expected %0d, got %0d", want.v, out_tdata[31:16]);
          fail_count++;
        end
      end
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    landmark_word_t w;
    pixel_result_t none;
    logic [12:0] rw;
    none = '{ST_VISIBLE, 16'd0, 16'd0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FOCAL_X;
    cfg_wdata = '0;
    focal_x = 16'd8000; focal_y = 16'd8000;
    center_x = 16'd5120; center_y = 16'd3840;
    img_w = 13'd640; img_h = 13'd480;
    mount_rot = ROT_IDENTITY; mount_ofs = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].res);
    wait_drained();
    repeat (30) @(posedge clk);

    for (int phase = 0; phase < 8; phase++) begin
      rw = 13'($urandom_range(1024, 64));
      case (phase)
        0: ;
        1: begin
          quiet = 1'b1;
          set_camera(16'($urandom_range(20000, 1000)), 16'($urandom_range(20000, 1000)),
                     {rw, 3'b000}, 16'(16'(rw) * 16'd6), rw, 13'(rw * 3 / 4),
                     near_axis_quat(), 48'd0);
        end
        2: begin
          quiet = 1'b0;
          set_camera(16'd0, 16'd0, 16'd5120, 16'd3840, 13'd0, 13'd8191, ROT_IDENTITY,
                     48'h8000_7FFF_8000);
          stall_req = 1'b1;
        end
        3: set_camera(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 13'd4096, 13'd1, ROT_IDENTITY,
                      48'h7FFF_8000_7FFF);
        4: set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      13'($urandom), 13'($urandom), {$urandom, $urandom},
                      48'({$urandom, $urandom}));
        default: set_camera(16'($urandom_range(20000, 1)), 16'($urandom_range(20000, 1)),
                            {rw, 3'b000}, 16'(16'(rw) * 16'd6),
                            13'($urandom_range(8191, 1)), 13'($urandom_range(8191, 1)),
                            near_axis_quat(),
                            48'({$urandom, $urandom}) & 48'h00FF_00FF_00FF);
      endcase
      for (int n = 0; n < 205; n++) begin
        if (phase == 3 && n == 100) wait_drained();
        w = random_word();
        send_word(w, 1'b0, none);
      end
      wait_drained();
      repeat (30) @(posedge clk);
    end

    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
